/* rtl/core/atsw_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the affine texture span writer
// no dependencies

package atsw_pkg;

  localparam int SCREEN_PIXELS = 128;
  localparam int TEXTURE_SIDE  = 32;
  localparam int SCREEN_LINES  = 256;

  localparam int TEX_BITS    = $clog2(TEXTURE_SIDE);
  localparam int TEX_ADDR_W  = 2 * TEX_BITS;
  localparam int STORE_DEPTH = TEXTURE_SIDE * TEXTURE_SIDE;
  localparam int FRAC_BITS   = 8;
  localparam int ACC_W       = FRAC_BITS + TEX_BITS;
  localparam int WORD_W      = $clog2(SCREEN_PIXELS / 2);

  localparam int INDEX_W    = 10;
  localparam int TEXEL_W    = 8;
  localparam int COL_W      = 7;
  localparam int LINE_W     = 8;
  localparam int FIX_W      = 16;
  localparam int FB_ADDR_W  = 14;
  localparam int FB_DATA_W  = 16;
  localparam int BE_W       = 2;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SPAN = 1'b1
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_SPAN
  } back_state_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [TEX_ADDR_W-1:0]   tex_index;
    logic [TEXEL_W-1:0]      tex_value;
    logic [WORD_W-1:0]       word_first;
    logic [WORD_W-1:0]       word_last;
    logic                    start_odd;
    logic                    end_even;
    logic [LINE_W-1:0]       line;
    logic [ACC_W-1:0]        u_init;
    logic [ACC_W-1:0]        v_init;
    logic [ACC_W-1:0]        u_step;
    logic [ACC_W-1:0]        v_step;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

/* rtl/core/atsw_front.sv */
`timescale 1ns / 1ps
// front end: unpacks input transfers, drops empty spans, builds queue commands
// depends on atsw_pkg

module atsw_front
  import atsw_pkg::*;
(
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  queue_stat_t          q_stat,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  localparam int COL_CMP_W  = COL_W + 1;
  localparam int LINE_CMP_W = LINE_W + 1;
  localparam int IDX_CMP_W  = INDEX_W + 1;

  logic [INDEX_W-1:0] texel_index;
  logic [TEXEL_W-1:0] texel_value;
  logic [COL_W-1:0]   span_start;
  logic [COL_W-1:0]   span_end;
  logic [LINE_W-1:0]  line;
  logic [FIX_W-1:0]   u_start;
  logic [FIX_W-1:0]   v_start;
  logic [FIX_W-1:0]   u_step;
  logic [FIX_W-1:0]   v_step;
  logic [COL_W-1:0]   end_clip;
  logic               span_ok;
  logic               load_ok;
  logic               keep;
  cmd_kind_t          kind;

  assign texel_index = s_tdata[9:0];
  assign texel_value = s_tdata[17:10];
  assign span_start  = s_tdata[24:18];
  assign span_end    = s_tdata[31:25];
  assign line        = s_tdata[39:32];
  assign u_start     = s_tdata[55:40];
  assign v_start     = s_tdata[71:56];
  assign u_step      = s_tdata[87:72];
  assign v_step      = s_tdata[103:88];

  always_comb begin
    kind     = cmd_kind_t'(s_tuser);
    end_clip = ({1'b0, span_end} > COL_CMP_W'(SCREEN_PIXELS - 1)) ?
               COL_W'(SCREEN_PIXELS - 1) : span_end;
    span_ok  = ({1'b0, line} < LINE_CMP_W'(SCREEN_LINES)) &&
               ({1'b0, span_start} < COL_CMP_W'(SCREEN_PIXELS)) &&
               (end_clip >= span_start);
    load_ok  = {1'b0, texel_index} < IDX_CMP_W'(STORE_DEPTH);
    keep     = (kind == CMD_SPAN) ? span_ok : load_ok;
    s_tready = !q_stat.full;
    q_push   = s_tvalid && s_tready && keep;

    q_cmd.kind       = kind;
    q_cmd.tex_index  = TEX_ADDR_W'(texel_index);
    q_cmd.tex_value  = texel_value;
    q_cmd.word_first = span_start[WORD_W:1];
    q_cmd.word_last  = end_clip[WORD_W:1];
    q_cmd.start_odd  = span_start[0];
    q_cmd.end_even   = !end_clip[0];
    q_cmd.line       = line;
    // first word samples its even pixel one step before the start when the start is odd
    q_cmd.u_init     = ACC_W'(u_start) - (span_start[0] ? ACC_W'(u_step) : ACC_W'(0));
    q_cmd.v_init     = ACC_W'(v_start) - (span_start[0] ? ACC_W'(v_step) : ACC_W'(0));
    q_cmd.u_step     = ACC_W'(u_step);
    q_cmd.v_step     = ACC_W'(v_step);
  end

endmodule

/* rtl/core/atsw_cmd_queue.sv */
`timescale 1ns / 1ps
// short command queue between front end and back end
// depends on atsw_pkg

module atsw_cmd_queue
  import atsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cmd_t        push_cmd,
  input  logic        pop,
  output queue_stat_t q_stat,
  output cmd_t        pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign pop_cmd      = slots[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.valid = (count != '0);

endmodule

/* rtl/core/atsw_back.sv */
`timescale 1ns / 1ps
// back end: texel store, span walker and output register
// depends on atsw_pkg

module atsw_back
  import atsw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  queue_stat_t           q_stat,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // word_address, word_data, byte_enable
  output logic                  m_tlast
);

  logic [TEXEL_W-1:0] texels [STORE_DEPTH];

  back_state_t state;
  back_state_t state_next;

  logic [WORD_W-1:0]     word;
  logic [WORD_W-1:0]     word_last;
  logic                  first;
  logic                  start_odd;
  logic                  end_even;
  logic [LINE_W-1:0]     line;
  logic [ACC_W-1:0]      u_acc;
  logic [ACC_W-1:0]      v_acc;
  logic [ACC_W-1:0]      u_step;
  logic [ACC_W-1:0]      v_step;

  logic                  out_valid;
  logic [FB_ADDR_W-1:0]  out_addr;
  logic [BE_W-1:0]       out_en;
  logic                  out_last;
  logic [TEXEL_W-1:0]    rd_hi;
  logic [TEXEL_W-1:0]    rd_lo;

  logic                  issue;
  logic                  mem_we;
  logic                  at_last;
  logic [ACC_W-1:0]      u_odd;
  logic [ACC_W-1:0]      v_odd;
  logic [TEX_ADDR_W-1:0] addr_even;
  logic [TEX_ADDR_W-1:0] addr_odd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    issue      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop = q_stat.valid;
        if (q_stat.valid && (q_cmd.kind == CMD_SPAN)) begin
          state_next = BK_SPAN;
        end
      end
      BK_SPAN: begin
        issue = !out_valid || m_tready;
        if (issue && at_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = q_pop && (q_cmd.kind == CMD_LOAD);
    at_last   = (word == word_last);
    u_odd     = u_acc + u_step;
    v_odd     = v_acc + v_step;
    addr_even = {v_acc[ACC_W-1:FRAC_BITS], u_acc[ACC_W-1:FRAC_BITS]};
    addr_odd  = {v_odd[ACC_W-1:FRAC_BITS], u_odd[ACC_W-1:FRAC_BITS]};
  end

  // texel store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      texels[q_cmd.tex_index] <= q_cmd.tex_value;
    end
    if (issue) begin
      rd_hi <= texels[addr_even];
      rd_lo <= texels[addr_odd];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.kind == CMD_SPAN)) begin
      word      <= q_cmd.word_first;
      word_last <= q_cmd.word_last;
      first     <= 1'b1;
      start_odd <= q_cmd.start_odd;
      end_even  <= q_cmd.end_even;
      line      <= q_cmd.line;
      u_acc     <= q_cmd.u_init;
      v_acc     <= q_cmd.v_init;
      u_step    <= q_cmd.u_step;
      v_step    <= q_cmd.v_step;
    end else if (issue) begin
      word     <= word + WORD_W'(1);
      first    <= 1'b0;
      u_acc    <= u_acc + {u_step[ACC_W-2:0], 1'b0};
      v_acc    <= v_acc + {v_step[ACC_W-2:0], 1'b0};
      out_addr <= FB_ADDR_W'(line) * FB_ADDR_W'(SCREEN_PIXELS / 2) + FB_ADDR_W'(word);
      out_en   <= {!(first && start_odd), !(at_last && end_even)};
      out_last <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {out_en,
                     (out_en[1] ? rd_hi : TEXEL_W'(0)),
                     (out_en[0] ? rd_lo : TEXEL_W'(0)),
                     out_addr};

endmodule

/* rtl/core/affine_texture_span_writer_top.sv */
`timescale 1ns / 1ps
// top level: front end, command queue, back end
// a load transfer is queued and written into the texel store when the idle back end pops it
// a span passes the queue slot, span registers and output register to its first word write,
// then one word per cycle unless m_tready stalls; the back end pops no command mid-span
// reset clears the control state only; the texel store holds nothing defined until loaded

module affine_texture_span_writer_top
  import atsw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // texel_index, texel_value, span_start, span_end,
                                           // line, u_start, v_start, u_step, v_step
  input  logic                  s_tuser,   // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // word_address, word_data, byte_enable
  output logic                  m_tlast    // last
);

  queue_stat_t q_stat;
  logic        q_push;
  logic        q_pop;
  cmd_t        push_cmd;
  cmd_t        pop_cmd;

  atsw_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  atsw_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .q_stat   (q_stat),
    .pop_cmd  (pop_cmd)
  );

  atsw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_pop_needs_entry : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.valid)
    else $error("back end popped an empty queue");

  a_word_has_byte : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_DATA_W-1:OUT_DATA_W-BE_W] != '0))
    else $error("word write with no byte enabled");

  a_full_after_push : assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(q_push))
    else $error("queue filled without a push");

endmodule

/* sim/affine_texture_span_writer_top_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for affine_texture_span_writer_top: texel loads and spans
// in, byte-enabled framebuffer word writes out, checked against an own span predictor
// depends on atsw_pkg and the top level

module affine_texture_span_writer_top_tb;
  import atsw_pkg::*;

  typedef struct {
    bit                       hold;   // pause marker: wait for all word writes
    cmd_kind_t                op;
    bit [INDEX_W-1:0]         index;
    bit [TEXEL_W-1:0]         value;
    bit [COL_W-1:0]           xs;
    bit [COL_W-1:0]           xe;
    bit [LINE_W-1:0]          line;
    bit signed [FIX_W-1:0]    u0;
    bit signed [FIX_W-1:0]    v0;
    bit signed [FIX_W-1:0]    du;
    bit signed [FIX_W-1:0]    dv;
  } stim_t;

  typedef struct {
    bit [FB_ADDR_W-1:0] addr;
    bit [FB_DATA_W-1:0] data;
    bit [BE_W-1:0]      be;
    bit                 last;
  } word_write_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  stim_t                 pending[$];
  word_write_t           word_writes_due[$];
  stim_t                 on_bus;
  bit                    planned [STORE_DEPTH];
  bit [TEXEL_W-1:0]      texel_copy [STORE_DEPTH];
  int                    words_outstanding = 0;
  int                    transfers_in = 0;
  int                    quiet_cycles = 0;
  int                    mismatches = 0;
  logic                  calm;

  assign calm = (transfers_in >= 120) && (transfers_in < 180);

  affine_texture_span_writer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("mismatch: %s", msg);
  endtask

  // texel row from v, column from u, both floor(x/256) mod side
  function automatic bit [TEX_ADDR_W-1:0] texel_addr(input stim_t it, input int k);
    int u;
    int v;
    u = int'(it.u0) + k * int'(it.du);
    v = int'(it.v0) + k * int'(it.dv);
    return {v[FRAC_BITS +: TEX_BITS], u[FRAC_BITS +: TEX_BITS]};
  endfunction

  function automatic int predict_span(input stim_t it);
    int          s;
    int          e;
    int          w;
    int          n;
    word_write_t ww;
    s = int'(it.xs);
    e = int'(it.xe);
    n = 0;
    if (e >= s) begin
      for (w = s / 2; w <= e / 2; w++) begin
        ww.data = '0;
        ww.be   = '0;
        if (2 * w >= s) begin
          ww.data[15:8] = texel_copy[texel_addr(it, 2 * w - s)];
          ww.be[1]      = 1'b1;
        end
        if (2 * w + 1 <= e) begin
          ww.data[7:0] = texel_copy[texel_addr(it, 2 * w + 1 - s)];
          ww.be[0]     = 1'b1;
        end
        ww.addr = FB_ADDR_W'(int'(it.line) * (SCREEN_PIXELS / 2) + w);
        ww.last = (w == e / 2);
        word_writes_due.push_back(ww);
        n++;
      end
    end
    return n;
  endfunction

  function automatic void queue_load(input bit [INDEX_W-1:0] idx, input bit [TEXEL_W-1:0] val);
    stim_t it;
    it.hold  = 1'b0;
    it.op    = CMD_LOAD;
    it.index = idx;
    it.value = val;
    it.xs    = COL_W'($urandom);
    it.xe    = COL_W'($urandom);
    it.line  = LINE_W'($urandom);
    it.u0    = FIX_W'($urandom);
    it.v0    = FIX_W'($urandom);
    it.du    = FIX_W'($urandom);
    it.dv    = FIX_W'($urandom);
    planned[idx] = 1'b1;
    pending.push_back(it);
  endfunction

  function automatic stim_t span_of(input bit [COL_W-1:0] xs, input bit [COL_W-1:0] xe,
                                    input bit [LINE_W-1:0] line,
                                    input bit signed [FIX_W-1:0] u0,
                                    input bit signed [FIX_W-1:0] v0,
                                    input bit signed [FIX_W-1:0] du,
                                    input bit signed [FIX_W-1:0] dv);
    stim_t it;
    it.hold  = 1'b0;
    it.op    = CMD_SPAN;
    it.index = INDEX_W'($urandom);
    it.value = TEXEL_W'($urandom);
    it.xs    = xs;
    it.xe    = xe;
    it.line  = line;
    it.u0    = u0;
    it.v0    = v0;
    it.du    = du;
    it.dv    = dv;
    return it;
  endfunction

  // every texel a span reads is loaded ahead of it
  function automatic void queue_span(input stim_t it);
    bit [TEX_ADDR_W-1:0] a;
    int                  k;
    for (k = 0; k <= int'(it.xe) - int'(it.xs); k++) begin
      a = texel_addr(it, k);
      if (!planned[a]) queue_load(a, TEXEL_W'($urandom));
    end
    pending.push_back(it);
  endfunction

  function automatic void queue_pause();
    stim_t it;
    it = span_of('0, '0, '0, '0, '0, '0, '0);
    it.hold = 1'b1;
    pending.push_back(it);
  endfunction

  function automatic bit signed [FIX_W-1:0] pick_step();
    case ($urandom_range(3))
      0:       return '0;
      1:       return FIX_W'(int'($urandom_range(0, 511)) - 256);
      2:       return FIX_W'($urandom);
      default: return FIX_W'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  function automatic stim_t random_span();
    stim_t it;
    int    len;
    it = span_of(COL_W'($urandom), '0, LINE_W'($urandom), FIX_W'($urandom),
                 FIX_W'($urandom), pick_step(), pick_step());
    case ($urandom_range(9))
      0: begin
        it.xe = COL_W'($urandom);
      end
      1, 2, 3: begin
        len   = $urandom_range(1, 40);
        it.xe = (int'(it.xs) + len - 1 > SCREEN_PIXELS - 1) ?
                COL_W'(SCREEN_PIXELS - 1) : COL_W'(int'(it.xs) + len - 1);
      end
      default: begin
        len   = $urandom_range(1, 8);
        it.xe = (int'(it.xs) + len - 1 > SCREEN_PIXELS - 1) ?
                COL_W'(SCREEN_PIXELS - 1) : COL_W'(int'(it.xs) + len - 1);
      end
    endcase
    return it;
  endfunction

  always @(posedge clk) begin : driver
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending.size() != 0 && pending[0].hold) begin
        s_tvalid <= 1'b0;
        if (!s_tvalid && words_outstanding == 0) void'(pending.pop_front());
      end else if (pending.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
        s_tvalid <= 1'b1;
        s_tuser  <= pending[0].op;
        s_tdata  <= {pending[0].dv, pending[0].du, pending[0].v0, pending[0].u0,
                     pending[0].line, pending[0].xe, pending[0].xs,
                     pending[0].value, pending[0].index};
        on_bus   <= pending[0];
        void'(pending.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= calm || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin : monitor
    word_write_t got;
    word_write_t want;
    int          added;
    added = 0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        transfers_in <= transfers_in + 1;
        if (on_bus.op == CMD_LOAD) texel_copy[on_bus.index] = on_bus.value;
        else added = predict_span(on_bus);
      end
      if (m_tvalid && m_tready) begin
        got.addr = m_tdata[FB_ADDR_W-1:0];
        got.data = m_tdata[FB_ADDR_W +: FB_DATA_W];
        got.be   = m_tdata[FB_ADDR_W + FB_DATA_W +: BE_W];
        got.last = m_tlast;
        if (word_writes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected word write address %h data %h", got.addr,
                                  got.data));
        end else begin
          want = word_writes_due.pop_front();
          added--;
          if (got.addr != want.addr)
            flag_mismatch($sformatf("address got %h want %h", got.addr, want.addr));
          if (got.data != want.data)
            flag_mismatch($sformatf("data at %h got %h want %h", want.addr, got.data,
                                    want.data));
          if (got.be != want.be)
            flag_mismatch($sformatf("byte enable at %h got %b want %b", want.addr, got.be,
                                    want.be));
          if (got.last != want.last)
            flag_mismatch($sformatf("last at %h got %b want %b", want.addr, got.last,
                                    want.last));
        end
      end
      words_outstanding <= words_outstanding + added;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 4000) begin
      $display("affine_texture_span_writer_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    bit paused;
    paused = 1'b0;

    // both values on every index and texel bit
    queue_load('0, 8'h00);
    queue_load(10'h3FF, 8'hFF);
    queue_load(10'h155, 8'hA5);
    queue_load(10'h2AA, 8'h5A);
    // whole line, last line
    queue_span(span_of(7'd0, 7'd127, 8'd255, 16'sh0000, 16'sh0000, 16'sh0010, 16'sh0000));
    // single odd pixel, single even pixel, aligned pair, partial words at both ends
    queue_span(span_of(7'd5, 7'd5, 8'd1, 16'sh0100, 16'sh0200, 16'sh0000, 16'sh0000));
    queue_span(span_of(7'd6, 7'd6, 8'd2, 16'sh0300, 16'sh0100, 16'sh0000, 16'sh0000));
    queue_span(span_of(7'd4, 7'd5, 8'd3, 16'sh0000, 16'sh0000, 16'sh0100, 16'sh0100));
    queue_span(span_of(7'd3, 7'd8, 8'd4, 16'sh0080, 16'sh1F00, 16'sh0100, -16'sh0100));
    // reversed spans write nothing
    queue_span(span_of(7'd10, 7'd9, 8'd5, 16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000));
    queue_span(span_of(7'd127, 7'd0, 8'd6, 16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000));
    // edge columns, first line
    queue_span(span_of(7'd127, 7'd127, 8'd7, 16'sh0500, 16'sh0600, 16'sh0100, 16'sh0100));
    queue_span(span_of(7'd0, 7'd0, 8'd0, 16'sh0000, 16'sh0000, 16'sh0100, 16'sh0100));
    // extreme and negative coordinates and steps
    queue_span(span_of(7'd0, 7'd7, 8'd9, 16'sh8000, -16'sh0001, 16'sh7FFF, 16'sh8000));
    queue_span(span_of(7'd120, 7'd127, 8'd128, 16'sh7FFF, 16'sh8000, -16'sh0001,
                       16'sh0001));
    queue_pause();

    while (pending.size() < 250) begin
      if (!paused && pending.size() >= 160) begin
        queue_pause();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 30) queue_load(INDEX_W'($urandom), TEXEL_W'($urandom));
      else                         queue_span(random_span());
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (rst || pending.size() != 0 || s_tvalid) @(negedge clk);
    while (words_outstanding != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (word_writes_due.size() != 0)
      flag_mismatch($sformatf("%0d word writes never arrived", word_writes_due.size()));
    if (mismatches == 0) begin
      $display("affine_texture_span_writer_top regression: pass");
    end else begin
      $display("affine_texture_span_writer_top regression: fail");
    end
    $finish;
  end

endmodule
